// File: src/apmt_pkg.sv
// ----------------------------------------------------------------------------
// apmt_pkg
// Shared types and codes for the action priority merge table.
// ----------------------------------------------------------------------------
package apmt_pkg;

    localparam logic REQ_OFFER = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic [11:0]        action;
        logic signed [23:0] prio;
        logic [9:0]         rule;
        logic [15:0]        link;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic load_req;
        logic srch_step;
        logic upd_write;
        logic app_write;
        logic set_ovf;
        logic fl_read;
        logic fl_load;
        logic fl_clear;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic better;
        logic at_count;
        logic full;
        logic idx_zero;
        logic out_free;
    } t_dp_sts;

endpackage

// File: src/action_priority_merge_table_unit.sv
// Offer: the search compares one stored entry per cycle through the table RAM's single
//   read port until a link hit or the end of the held entries.
// Flush: held entries are read newest first through states FRD and FOUT; each goes to
//   the output register once it is free, so output stalls hold the readout.
// Reset (i_rst_n low, synchronous) empties the table and clears the overflow mark
//   and the output valid; table RAM contents and output data are not cleared.
// ----------------------------------------------------------------------------
// action_priority_merge_table_unit
// Per-link merge of candidate actions by priority, flushed newest first.
// ----------------------------------------------------------------------------
module action_priority_merge_table_unit #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // link_index[15:0], rule_index[25:16], rule_priority[49:26], action_ref[61:50]
    input  logic [apmt_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // req_type[0]
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // out_link[15:0], out_rule[25:16], out_action[37:26]
    output logic [apmt_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                             o_m_axis_tlast,
    // overflowed[0]
    output logic                             o_m_axis_tuser
);
    import apmt_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    apmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_kind  (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    apmt_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_s_axis_tdata),
        .i_in_kind   (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast),
        .o_out_ovf   (o_m_axis_tuser)
    );

endmodule

// File: src/apmt_ram.sv
// ----------------------------------------------------------------------------
// apmt_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module apmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/apmt_datapath.sv
// ----------------------------------------------------------------------------
// apmt_datapath
// Entry table, search/flush index, fill count, overflow mark, output register.
// ----------------------------------------------------------------------------
module apmt_datapath #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  apmt_pkg::t_dp_cmd               i_cmd,
    output apmt_pkg::t_dp_sts               o_sts,
    input  logic [apmt_pkg::IN_TDATA_W-1:0] i_in_data,
    input  logic                            i_in_kind,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [apmt_pkg::OUT_TDATA_W-1:0] o_out_data,
    output logic                            o_out_last,
    output logic                            o_out_ovf
);
    import apmt_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    t_entry          r_req;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic            r_out_valid;
    logic [15:0]     r_out_link;
    logic [9:0]      r_out_rule;
    logic [11:0]     r_out_action;
    logic            r_out_last;
    logic            r_out_ovf;

    logic [CW-1:0]   idx_dec;
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    t_entry          ram_rdata;

    assign idx_dec   = r_idx - 1'b1;
    assign ram_we    = i_cmd.upd_write | i_cmd.app_write;
    assign ram_waddr = i_cmd.upd_write ? idx_dec[AW-1:0] : r_count[AW-1:0];
    assign ram_re    = i_cmd.srch_step | i_cmd.fl_read;
    assign ram_raddr = i_cmd.srch_step ? r_idx[AW-1:0] : idx_dec[AW-1:0];

    apmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_req),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_idx   = r_idx;
        n_count = r_count;
        n_ovf   = r_ovf;
        if (i_cmd.load_req) begin
            n_idx = (i_in_kind == REQ_FLUSH) ? r_count : '0;
        end else if (i_cmd.srch_step) begin
            n_idx = r_idx + 1'b1;
        end else if (i_cmd.fl_read) begin
            n_idx = idx_dec;
        end
        if (i_cmd.app_write) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.fl_clear) begin
            n_count = '0;
        end
        if (i_cmd.set_ovf) begin
            n_ovf = 1'b1;
        end else if (i_cmd.fl_clear) begin
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            if (i_cmd.fl_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= t_entry'(i_in_data[ENTRY_W-1:0]);
        end
        if (i_cmd.fl_load) begin
            r_out_link   <= ram_rdata.link;
            r_out_rule   <= ram_rdata.rule;
            r_out_action <= ram_rdata.action;
            r_out_last   <= (r_idx == '0);
            r_out_ovf    <= r_ovf;
        end
    end

    assign o_sts.hit      = (r_idx != '0) && (ram_rdata.link == r_req.link);
    assign o_sts.better   = r_req.prio > ram_rdata.prio;
    assign o_sts.at_count = (r_idx == r_count);
    assign o_sts.full     = (r_count == CW'(MAX_ENTRIES));
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {2'b00, r_out_action, r_out_rule, r_out_link};
    assign o_out_last  = r_out_last;
    assign o_out_ovf   = r_out_ovf;

endmodule

// File: src/apmt_ctrl.sv
// ----------------------------------------------------------------------------
// apmt_ctrl
// Sequencer for offer search/merge and flush readout.
// ----------------------------------------------------------------------------
module apmt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_kind,
    output logic              o_in_ready,
    output apmt_pkg::t_dp_cmd o_cmd,
    input  apmt_pkg::t_dp_sts i_sts
);
    import apmt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SRCH = 4'b0010,
        ST_FRD  = 4'b0100,
        ST_FOUT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state = (i_in_kind == REQ_FLUSH) ? ST_FRD : ST_SRCH;
                end
            end
            ST_SRCH: begin
                priority if (i_sts.hit) begin
                    o_cmd.upd_write = i_sts.better;
                    n_state = ST_IDLE;
                end else if (i_sts.at_count) begin
                    o_cmd.app_write = !i_sts.full;
                    o_cmd.set_ovf   = i_sts.full;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.srch_step = 1'b1;
                end
            end
            ST_FRD: begin
                if (i_sts.idx_zero) begin
                    o_cmd.fl_clear = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.fl_read = 1'b1;
                    n_state = ST_FOUT;
                end
            end
            ST_FOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.fl_load = 1'b1;
                    n_state = ST_FRD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/apmt_checker.sv
// ----------------------------------------------------------------------------
// apmt_checker
// Port-level checks for the merge table, bound to the top level.
// ----------------------------------------------------------------------------
module apmt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [apmt_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                             i_s_axis_tuser,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [apmt_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                             o_m_axis_tlast,
    input logic                             o_m_axis_tuser
);
    import apmt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))
        else $error("output payload changed while stalled");

    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == REQ_FLUSH)
            |=> !o_s_axis_tready)
        else $error("input accepted during flush readout");

    a_out_from_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("output transaction started outside flush readout");

endmodule

bind action_priority_merge_table_unit apmt_checker u_apmt_checker (.*);

// File: bench/tb_action_priority_merge_table_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_action_priority_merge_table_unit
// Self-checking bench: offers and flushes are streamed into the merge table,
// a local copy of the table predicts every flushed entry, and the monitor
// compares each output transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_action_priority_merge_table_unit;
    import apmt_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int RANDOM_ITEMS  = 130;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        logic        kind;
        logic [15:0] link;
        logic [9:0]  rule;
        logic [23:0] prio;
        logic [11:0] action;
        bit          drain_first;
    } merge_req_t;

    typedef struct packed {
        logic [15:0] link;
        logic [9:0]  rule;
        logic [11:0] action;
        logic        last;
        logic        ovf;
    } flush_beat_t;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    merge_req_t  req_q[$];
    merge_req_t  nxt;
    flush_beat_t beat_q[$];
    flush_beat_t want;

    t_entry held_tab[TABLE_DEPTH];
    int     held_cnt = 0;
    bit     held_ovf = 1'b0;

    bit drv_busy = 1'b0;
    bit moved;
    int idle_run = 0;
    int acc_in = 0;
    int err_cnt = 0;
    int offer_cnt = 0;
    int flush_cnt = 0;
    int beat_cnt = 0;
    int ovf_pass_cnt = 0;

    wire calm = (acc_in >= 40 && acc_in < 100);

    action_priority_merge_table_unit #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tlast (m_tlast),
        .o_m_axis_tuser (m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // table predictor, updated on every accepted input transaction
    task automatic merge_request(input logic kind, input logic [IN_TDATA_W-1:0] data);
        t_entry      offer;
        bit          found;
        flush_beat_t beat;
        offer = data[ENTRY_W-1:0];
        found = 1'b0;
        if (kind == REQ_OFFER) begin
            for (int k = 0; k < held_cnt; k++) begin
                if (!found && held_tab[k].link == offer.link) begin
                    found = 1'b1;
                    if ($signed(offer.prio) > $signed(held_tab[k].prio)) begin
                        held_tab[k] = offer;
                    end
                end
            end
            if (!found) begin
                if (held_cnt < TABLE_DEPTH) begin
                    held_tab[held_cnt] = offer;
                    held_cnt++;
                end else begin
                    held_ovf = 1'b1;
                end
            end
            offer_cnt++;
        end else begin
            for (int r = held_cnt - 1; r >= 0; r--) begin
                beat.link   = held_tab[r].link;
                beat.rule   = held_tab[r].rule;
                beat.action = held_tab[r].action;
                beat.last   = (r == 0);
                beat.ovf    = held_ovf;
                beat_q.push_back(beat);
            end
            if (held_ovf) begin
                ovf_pass_cnt++;
            end
            held_cnt = 0;
            held_ovf = 1'b0;
            flush_cnt++;
        end
    endtask

    task automatic push_offer(input logic [15:0] link, input logic [9:0] rule,
                              input logic [23:0] prio, input logic [11:0] action);
        merge_req_t req;
        req.kind        = REQ_OFFER;
        req.link        = link;
        req.rule        = rule;
        req.prio        = prio;
        req.action      = action;
        req.drain_first = 1'b0;
        req_q.push_back(req);
    endtask

    // payload of a flush is don't-care, so it carries random bits
    task automatic push_flush(input bit drain_first);
        merge_req_t req;
        req.kind        = REQ_FLUSH;
        req.link        = 16'($urandom);
        req.rule        = 10'($urandom);
        req.prio        = 24'($urandom);
        req.action      = 12'($urandom);
        req.drain_first = drain_first;
        req_q.push_back(req);
    endtask

    // mostly full-range priorities, sometimes a narrow band to force ties
    function automatic logic [23:0] pick_prio();
        if ($urandom_range(2) == 0) begin
            return 24'($urandom_range(4)) - 24'd2;
        end
        return 24'($urandom);
    endfunction

    initial begin : stimulus
        logic [15:0] pool[4];
        logic [15:0] base;
        int          n_rand;
        int          pass_len;
        bit          big_done;

        push_flush(1'b0);
        push_offer(16'h0000, 10'd0,    24'h800000, 12'h000);
        push_offer(16'hFFFF, 10'd1023, 24'h7FFFFF, 12'hFFF);
        push_offer(16'h0000, 10'd5,    24'h800000, 12'h007);
        push_offer(16'h0000, 10'd1023, 24'h800001, 12'hFFF);
        push_offer(16'hFFFF, 10'd3,    24'h000000, 12'h123);
        push_offer(16'h1234, 10'd10,   24'h000100, 12'h456);
        push_offer(16'h1234, 10'd11,   24'h0000FF, 12'h789);
        push_offer(16'h1234, 10'd12,   24'h000101, 12'hABC);
        push_offer(16'hA5A5, 10'd341,  24'hFFFFFF, 12'h555);
        push_offer(16'hA5A5, 10'd682,  24'h000000, 12'hAAA);
        push_offer(16'h5A5A, 10'd100,  24'h7FFFFF, 12'h0F0);
        push_offer(16'h5A5A, 10'd200,  24'h800000, 12'hF0F);
        push_flush(1'b1);
        push_flush(1'b1);
        push_offer(16'h00FF, 10'd512,  24'h123456, 12'h800);
        push_flush(1'b0);
        push_offer(16'hFF00, 10'd256,  24'hFEDCBA, 12'h001);
        push_offer(16'hFF00, 10'd257,  24'hFEDCBA, 12'h002);
        push_flush(1'b0);

        n_rand   = 0;
        big_done = 1'b0;
        while (n_rand < RANDOM_ITEMS) begin
            if (!big_done && n_rand >= 20) begin
                // fill the table, then mix hits on held links with dropped new links
                base = 16'($urandom);
                for (int k = 0; k < TABLE_DEPTH; k++) begin
                    push_offer(base + 16'(k * 37), 10'($urandom), pick_prio(), 12'($urandom));
                end
                for (int k = 0; k < 6; k++) begin
                    if ($urandom_range(1) == 1) begin
                        push_offer(base + 16'($urandom_range(TABLE_DEPTH - 1) * 37),
                                   10'($urandom), pick_prio(), 12'($urandom));
                    end else begin
                        push_offer(base + 16'(TABLE_DEPTH * 37 + k),
                                   10'($urandom), pick_prio(), 12'($urandom));
                    end
                end
                push_flush(1'($urandom_range(1)));
                n_rand  += TABLE_DEPTH + 7;
                big_done = 1'b1;
            end else if ($urandom_range(7) == 0) begin
                push_flush(1'($urandom_range(1)));
                n_rand++;
            end else begin
                pass_len = $urandom_range(12, 1);
                foreach (pool[p]) begin
                    pool[p] = 16'($urandom);
                end
                for (int k = 0; k < pass_len; k++) begin
                    push_offer(($urandom_range(3) == 0) ? 16'($urandom) : pool[$urandom_range(3)],
                               10'($urandom), pick_prio(), 12'($urandom));
                end
                push_flush($urandom_range(3) == 0);
                n_rand += pass_len + 1;
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (req_q.size() == 0 && !drv_busy);
        wait (beat_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d offers and %0d flushes, %0d flushed entries checked,",
                 offer_cnt, flush_cnt, beat_cnt);
        $display("including %0d pass(es) that overflowed the table.", ovf_pass_cnt);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // driver: new transaction presented on the falling edge once the last one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!drv_busy) begin
            if (req_q.size() > 0 && (calm || $urandom_range(99) >= 25)
                    && !(req_q[0].drain_first && beat_q.size() != 0)) begin
                nxt = req_q.pop_front();
                s_tdata  <= {2'b00, nxt.action, nxt.prio, nxt.rule, nxt.link};
                s_tuser  <= nxt.kind;
                s_tvalid <= 1'b1;
                drv_busy = 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= i_rst_n && (calm || $urandom_range(99) >= 25);
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (s_tvalid && s_tready) begin
                merge_request(s_tuser, s_tdata);
                drv_busy = 1'b0;
                acc_in++;
                moved = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                if (beat_q.size() == 0) begin
                    $error("unexpected result: out_link %h", m_tdata[15:0]);
                    err_cnt++;
                end else begin
                    want = beat_q.pop_front();
                    beat_cnt++;
                    if (m_tdata[15:0] !== want.link) begin
                        $error("out_link expected %h actual %h", want.link, m_tdata[15:0]);
                        err_cnt++;
                    end
                    if (m_tdata[25:16] !== want.rule) begin
                        $error("out_rule expected %0d actual %0d", want.rule, m_tdata[25:16]);
                        err_cnt++;
                    end
                    if (m_tdata[37:26] !== want.action) begin
                        $error("out_action expected %h actual %h", want.action, m_tdata[37:26]);
                        err_cnt++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_entry expected %b actual %b", want.last, m_tlast);
                        err_cnt++;
                    end
                    if (m_tuser !== want.ovf) begin
                        $error("overflowed expected %b actual %b", want.ovf, m_tuser);
                        err_cnt++;
                    end
                end
            end
            idle_run = moved ? 0 : idle_run + 1;
            if (idle_run >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

// File: files.f
src/apmt_pkg.sv
src/apmt_ram.sv
src/apmt_datapath.sv
src/apmt_ctrl.sv
src/action_priority_merge_table_unit.sv
src/apmt_checker.sv
bench/tb_action_priority_merge_table_unit.sv
